// ===== rtl/trig_differential_drive_mixer_core_macros.svh =====
// assertion shorthands, clocked on clk and held off while rst_n is low
`ifndef TRIG_DIFFERENTIAL_DRIVE_MIXER_CORE_MACROS_SVH
`define TRIG_DIFFERENTIAL_DRIVE_MIXER_CORE_MACROS_SVH

// same-cycle implication
`define TDDM_ASSERT_NOW(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tddm check failed");

// next-cycle implication
`define TDDM_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tddm check failed");

`endif

// ===== rtl/tddm_pkg.sv =====
package tddm_pkg;

    localparam int DIV_W = 15;

    typedef enum logic [1:0] {
        CFG_MOVE_POS = 2'd0,
        CFG_MOVE_NEG = 2'd1,
        CFG_ROT_POS  = 2'd2,
        CFG_ROT_NEG  = 2'd3
    } cfg_index_t;

    localparam logic [DIV_W-1:0] RST_MOVE_POS = 15'd32440;
    localparam logic [DIV_W-1:0] RST_MOVE_NEG = 15'd19661;
    localparam logic [DIV_W-1:0] RST_ROT_POS  = 15'd32440;
    localparam logic [DIV_W-1:0] RST_ROT_NEG  = 15'd32440;

endpackage

// ===== rtl/trig_differential_drive_mixer_core.sv =====
// channel   dir  beat contents (lowest bits first)
// s_*       in   move_in, rotate_in
// m_*       out  left_drive, right_drive
// cfg_*     in   divisor write, index 0..3
//
// one beat per cycle sustained while m_tready stays high;
// one stage per quotient bit and per root digit
// rst_n clears the stage valid bits and loads the default divisors
// each stage advances when the one after it is empty or moving,
// so a stalled output leaves bubbles free to close up
`include "trig_differential_drive_mixer_core_macros.svh"

module trig_differential_drive_mixer_core #(
    parameter int SAMPLE_BITS = 16,
    localparam int TDW = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [TDW-1:0]           s_tdata,   // move_in, rotate_in
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [TDW-1:0]           m_tdata,   // left_drive, right_drive
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [tddm_pkg::DIV_W-1:0] cfg_data
);

    localparam int W    = SAMPLE_BITS;
    localparam int F    = W - 1;
    localparam int K    = W;
    localparam int DV   = tddm_pkg::DIV_W;
    localparam int CS   = W + 1;
    localparam int CHW  = 2 * DV + CS + 3;
    localparam int ST_B = CS + 1;
    localparam int ST_C = CS + 2;
    localparam int ST_D = CS + 3;
    localparam int SQ0  = CS + 4;
    localparam int ST_E = CS + 4 + K;
    localparam int OD0  = CS + 5 + K;
    localparam int ST_F = CS + 5 + 2 * K;
    localparam int NST  = CS + 6 + 2 * K;
    localparam logic [K-1:0] ONE  = {1'b1, {F{1'b0}}};
    localparam logic [W-1:0] MAXV = {1'b0, {F{1'b1}}};

    logic [DV-1:0] move_pos_reg;
    logic [DV-1:0] move_neg_reg;
    logic [DV-1:0] rot_pos_reg;
    logic [DV-1:0] rot_neg_reg;

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;
    logic [NST-1:0] en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_pos_reg <= tddm_pkg::RST_MOVE_POS;
            move_neg_reg <= tddm_pkg::RST_MOVE_NEG;
            rot_pos_reg  <= tddm_pkg::RST_ROT_POS;
            rot_neg_reg  <= tddm_pkg::RST_ROT_NEG;
        end
        else if (cfg_we)
        begin
            case (tddm_pkg::cfg_index_t'(cfg_index))
                tddm_pkg::CFG_MOVE_POS: move_pos_reg <= cfg_data;
                tddm_pkg::CFG_MOVE_NEG: move_neg_reg <= cfg_data;
                tddm_pkg::CFG_ROT_POS:  rot_pos_reg  <= cfg_data;
                tddm_pkg::CFG_ROT_NEG:  rot_neg_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage handshake chain
    always_comb
    begin
        en[NST-1] = !valid_reg[NST-1] || m_tready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = s_tvalid;
        end
        for (int i = 1; i < NST; i++)
        begin
            if (en[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[NST-1];

    // compensation set-up
    logic          mv_neg, rt_neg;
    logic [W-1:0]  mv_mag, rt_mag;
    logic [DV-1:0] mv_den, rt_den;
    logic [W+DV-1:0] mv_wide, rt_wide;
    logic          mv_ovf, rt_ovf;
    logic [CHW-1:0] p0_mv_d, p0_rt_d, p0_mv_q, p0_rt_q;

    always_comb
    begin
        mv_neg  = s_tdata[W-1];
        rt_neg  = s_tdata[2*W-1];
        mv_mag  = mv_neg ? (~s_tdata[W-1:0] + W'(1)) : s_tdata[W-1:0];
        rt_mag  = rt_neg ? (~s_tdata[2*W-1:W] + W'(1)) : s_tdata[2*W-1:W];
        mv_den  = mv_neg ? move_neg_reg : move_pos_reg;
        rt_den  = rt_neg ? rot_neg_reg : rot_pos_reg;
        mv_wide = {mv_mag, {DV{1'b0}}};
        rt_wide = {rt_mag, {DV{1'b0}}};
        mv_ovf  = (mv_den == '0) || ({1'b0, mv_wide[W+DV-1:W+1]} >= mv_den);
        rt_ovf  = (rt_den == '0) || ({1'b0, rt_wide[W+DV-1:W+1]} >= rt_den);
        p0_mv_d = {mv_den, 1'b0, mv_wide[W+DV-1:W+1], mv_wide[W:0],
                   (mv_mag == '0), mv_ovf, mv_neg};
        p0_rt_d = {rt_den, 1'b0, rt_wide[W+DV-1:W+1], rt_wide[W:0],
                   (rt_mag == '0), rt_ovf, rt_neg};
    end

    tddm_stage #(.WIDTH(2 * CHW)) u_p0 (
        .clk (clk),
        .en  (en[0]),
        .d   ({p0_rt_d, p0_mv_d}),
        .q   ({p0_rt_q, p0_mv_q})
    );

    // compensation dividers, one quotient bit per cell
    logic [DV-1:0] cm_den [CS+1];
    logic [DV-1:0] cm_rem [CS+1];
    logic [W:0]    cm_num [CS+1];
    logic [W:0]    cm_q   [CS+1];
    logic [2:0]    cm_sd  [CS+1];
    logic [DV-1:0] cr_den [CS+1];
    logic [DV-1:0] cr_rem [CS+1];
    logic [W:0]    cr_num [CS+1];
    logic [W:0]    cr_q   [CS+1];
    logic [2:0]    cr_sd  [CS+1];

    assign {cm_den[0], cm_rem[0], cm_num[0], cm_sd[0]} = p0_mv_q;
    assign {cr_den[0], cr_rem[0], cr_num[0], cr_sd[0]} = p0_rt_q;
    assign cm_q[0] = '0;
    assign cr_q[0] = '0;

    for (genvar j = 0; j < CS; j++)
    begin : g_comp
        tddm_div_cell #(.DW(DV), .NW(W + 1), .QW(W + 1), .SW(3)) u_mv (
            .clk      (clk),
            .en       (en[1+j]),
            .den_in   (cm_den[j]),
            .rem_in   (cm_rem[j]),
            .num_in   (cm_num[j]),
            .q_in     (cm_q[j]),
            .side_in  (cm_sd[j]),
            .den_out  (cm_den[j+1]),
            .rem_out  (cm_rem[j+1]),
            .num_out  (cm_num[j+1]),
            .q_out    (cm_q[j+1]),
            .side_out (cm_sd[j+1])
        );
        tddm_div_cell #(.DW(DV), .NW(W + 1), .QW(W + 1), .SW(3)) u_rt (
            .clk      (clk),
            .en       (en[1+j]),
            .den_in   (cr_den[j]),
            .rem_in   (cr_rem[j]),
            .num_in   (cr_num[j]),
            .q_in     (cr_q[j]),
            .side_in  (cr_sd[j]),
            .den_out  (cr_den[j+1]),
            .rem_out  (cr_rem[j+1]),
            .num_out  (cr_num[j+1]),
            .q_out    (cr_q[j+1]),
            .side_out (cr_sd[j+1])
        );
    end

    // saturate the quotient magnitudes to one
    logic [K-1:0] a_val, b_val;
    logic         rt_pos;
    logic [K-1:0] b_a, b_b;
    logic         b_mneg, b_rpos;

    always_comb
    begin
        if (cm_sd[CS][2])
            a_val = '0;
        else if (cm_sd[CS][1] || (cm_q[CS] > {1'b0, ONE}))
            a_val = ONE;
        else
            a_val = cm_q[CS][K-1:0];
        if (cr_sd[CS][2])
            b_val = '0;
        else if (cr_sd[CS][1] || (cr_q[CS] > {1'b0, ONE}))
            b_val = ONE;
        else
            b_val = cr_q[CS][K-1:0];
        rt_pos = !cr_sd[CS][0] && (b_val != '0);
    end

    tddm_stage #(.WIDTH(2 * K + 2)) u_sb (
        .clk (clk),
        .en  (en[ST_B]),
        .d   ({a_val, b_val, cm_sd[CS][0], rt_pos}),
        .q   ({b_a, b_b, b_mneg, b_rpos})
    );

    // squares
    logic [2*K-1:0] c_aa, c_bb;
    logic [K-1:0]   c_a, c_b;
    logic           c_mneg, c_rpos;

    tddm_stage #(.WIDTH(6 * K + 2)) u_sc (
        .clk (clk),
        .en  (en[ST_C]),
        .d   ({{{K{1'b0}}, b_a} * {{K{1'b0}}, b_a},
               {{K{1'b0}}, b_b} * {{K{1'b0}}, b_b},
               b_a, b_b, b_mneg, b_rpos}),
        .q   ({c_aa, c_bb, c_a, c_b, c_mneg, c_rpos})
    );

    // sum of squares, then root digits
    localparam int SQS = 4 * K + 2;
    logic [2*K-1:0] sq_rad  [K+1];
    logic [K+1:0]   sq_rem  [K+1];
    logic [K-1:0]   sq_root [K+1];
    logic [SQS-1:0] sq_sd   [K+1];

    tddm_stage #(.WIDTH(2 * K + SQS)) u_sd (
        .clk (clk),
        .en  (en[ST_D]),
        .d   ({c_aa + c_bb, c_a, c_b, c_aa, c_mneg, c_rpos}),
        .q   ({sq_rad[0], sq_sd[0]})
    );

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar j = 0; j < K; j++)
    begin : g_sqrt
        tddm_sqrt_cell #(.K(K), .SW(SQS)) u_sq (
            .clk      (clk),
            .en       (en[SQ0+j]),
            .rad_in   (sq_rad[j]),
            .rem_in   (sq_rem[j]),
            .root_in  (sq_root[j]),
            .side_in  (sq_sd[j]),
            .rad_out  (sq_rad[j+1]),
            .rem_out  (sq_rem[j+1]),
            .root_out (sq_root[j+1]),
            .side_out (sq_sd[j+1])
        );
    end

    // inside numerator
    logic [K-1:0]   e_a, e_b, e_hb;
    logic [2*K-1:0] e_aa;
    logic           e_mneg, e_rpos;
    logic [K-1:0]   e_h;
    logic [2*K-1:0] e_aaq, e_amq;
    logic           e_mnegq, e_rposq, e_azq;

    assign {e_a, e_b, e_aa, e_mneg, e_rpos} = sq_sd[K];
    assign e_hb = sq_root[K] - e_b;

    tddm_stage #(.WIDTH(5 * K + 3)) u_se (
        .clk (clk),
        .en  (en[ST_E]),
        .d   ({sq_root[K], e_aa, {{K{1'b0}}, e_a} * {{K{1'b0}}, e_hb},
               e_mneg, e_rpos, (e_a == '0)}),
        .q   ({e_h, e_aaq, e_amq, e_mnegq, e_rposq, e_azq})
    );

    // outside and inside quotients
    logic [K-1:0] ot_den [K+1];
    logic [K-1:0] ot_rem [K+1];
    logic [K-1:0] ot_num [K+1];
    logic [K-1:0] ot_q   [K+1];
    logic [1:0]   ot_sd  [K+1];
    logic [K-1:0] ins_den [K+1];
    logic [K-1:0] ins_rem [K+1];
    logic [K-1:0] ins_num [K+1];
    logic [K-1:0] ins_q   [K+1];
    logic [0:0]   ins_sd  [K+1];

    assign ot_den[0]  = e_h;
    assign ot_rem[0]  = e_aaq[2*K-1:K];
    assign ot_num[0]  = e_aaq[K-1:0];
    assign ot_q[0]    = '0;
    assign ot_sd[0]   = {e_mnegq, e_rposq};
    assign ins_den[0] = e_h;
    assign ins_rem[0] = e_amq[2*K-1:K];
    assign ins_num[0] = e_amq[K-1:0];
    assign ins_q[0]   = '0;
    assign ins_sd[0]  = e_azq;

    for (genvar j = 0; j < K; j++)
    begin : g_wheel
        tddm_div_cell #(.DW(K), .NW(K), .QW(K), .SW(2)) u_ot (
            .clk      (clk),
            .en       (en[OD0+j]),
            .den_in   (ot_den[j]),
            .rem_in   (ot_rem[j]),
            .num_in   (ot_num[j]),
            .q_in     (ot_q[j]),
            .side_in  (ot_sd[j]),
            .den_out  (ot_den[j+1]),
            .rem_out  (ot_rem[j+1]),
            .num_out  (ot_num[j+1]),
            .q_out    (ot_q[j+1]),
            .side_out (ot_sd[j+1])
        );
        tddm_div_cell #(.DW(K), .NW(K), .QW(K), .SW(1)) u_ins (
            .clk      (clk),
            .en       (en[OD0+j]),
            .den_in   (ins_den[j]),
            .rem_in   (ins_rem[j]),
            .num_in   (ins_num[j]),
            .q_in     (ins_q[j]),
            .side_in  (ins_sd[j]),
            .den_out  (ins_den[j+1]),
            .rem_out  (ins_rem[j+1]),
            .num_out  (ins_num[j+1]),
            .q_out    (ins_q[j+1]),
            .side_out (ins_sd[j+1])
        );
    end

    // sign, wheel choice, negate and clamp
    logic [W-1:0] ot_c, ins_c, ot_drv, ins_drv, left_n, right_n;

    always_comb
    begin
        ot_c    = (ot_q[K] > MAXV) ? MAXV : ot_q[K];
        ins_c   = (ins_q[K] > MAXV) ? MAXV : ins_q[K];
        ot_drv  = ot_sd[K][1] ? ot_c : (~ot_c + W'(1));
        ins_drv = ot_sd[K][1] ? ins_c : (~ins_c + W'(1));
        if (ins_sd[K][0])
        begin
            left_n  = '0;
            right_n = '0;
        end
        else if (ot_sd[K][0])
        begin
            left_n  = ot_drv;
            right_n = ins_drv;
        end
        else
        begin
            left_n  = ins_drv;
            right_n = ot_drv;
        end
    end

    tddm_stage #(.WIDTH(TDW)) u_sf (
        .clk (clk),
        .en  (en[ST_F]),
        .d   (TDW'({right_n, left_n})),
        .q   (m_tdata)
    );

    `TDDM_ASSERT_NOW(a_ready_when_out_empty, !valid_reg[NST-1], s_tready)
    `TDDM_ASSERT_NEXT(a_accept_fills_first, s_tvalid && s_tready, valid_reg[0])
    `TDDM_ASSERT_NOW(a_no_full_scale, m_tvalid,
        (m_tdata[W-1:0] != {1'b1, {F{1'b0}}}) && (m_tdata[2*W-1:W] != {1'b1, {F{1'b0}}}))

endmodule

// ===== rtl/tddm_stage.sv =====
module tddm_stage #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule

// ===== rtl/tddm_div_cell.sv =====
module tddm_div_cell #(
    parameter int DW = 15,
    parameter int NW = 17,
    parameter int QW = 17,
    parameter int SW = 3
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] den_in,
    input  logic [DW-1:0] rem_in,
    input  logic [NW-1:0] num_in,
    input  logic [QW-1:0] q_in,
    input  logic [SW-1:0] side_in,
    output logic [DW-1:0] den_out,
    output logic [DW-1:0] rem_out,
    output logic [NW-1:0] num_out,
    output logic [QW-1:0] q_out,
    output logic [SW-1:0] side_out
);

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_next;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [NW-1:0] num_reg;
    logic [QW-1:0] q_reg;
    logic [SW-1:0] side_reg;

    // one restoring step: bring down the next numerator bit
    always_comb
    begin
        trial    = {rem_in, num_in[NW-1]};
        ge       = trial >= {1'b0, den_in};
        diff     = trial - {1'b0, den_in};
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg  <= den_in;
            rem_reg  <= rem_next;
            num_reg  <= num_in << 1;
            q_reg    <= {q_in[QW-2:0], ge};
            side_reg <= side_in;
        end
    end

    assign den_out  = den_reg;
    assign rem_out  = rem_reg;
    assign num_out  = num_reg;
    assign q_out    = q_reg;
    assign side_out = side_reg;

endmodule

// ===== rtl/tddm_sqrt_cell.sv =====
module tddm_sqrt_cell #(
    parameter int K  = 16,
    parameter int SW = 8
) (
    input  logic           clk,
    input  logic           en,
    input  logic [2*K-1:0] rad_in,
    input  logic [K+1:0]   rem_in,
    input  logic [K-1:0]   root_in,
    input  logic [SW-1:0]  side_in,
    output logic [2*K-1:0] rad_out,
    output logic [K+1:0]   rem_out,
    output logic [K-1:0]   root_out,
    output logic [SW-1:0]  side_out
);

    logic [K+3:0]   cur;
    logic [K+3:0]   trial;
    logic [K+3:0]   diff;
    logic           ge;
    logic [K+1:0]   rem_next;
    logic [2*K-1:0] rad_reg;
    logic [K+1:0]   rem_reg;
    logic [K-1:0]   root_reg;
    logic [SW-1:0]  side_reg;

    // one root digit per cell, two radicand bits brought down
    always_comb
    begin
        cur      = {rem_in, rad_in[2*K-1:2*K-2]};
        trial    = {2'b00, root_in, 2'b01};
        ge       = cur >= trial;
        diff     = cur - trial;
        rem_next = ge ? diff[K+1:0] : cur[K+1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_in << 2;
            rem_reg  <= rem_next;
            root_reg <= {root_in[K-2:0], ge};
            side_reg <= side_in;
        end
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule
